>>> design/nearest_climate_entry_select_macros.svh
// Assertion macros shared by the climate entry selector.
`ifndef NEAREST_CLIMATE_ENTRY_SELECT_MACROS_SVH
`define NEAREST_CLIMATE_ENTRY_SELECT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define NCES_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define NCES_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NCES_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define NCES_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> design/nces_pkg.sv
// Shared constants and controller/datapath interface types of the climate entry selector.
package nces_pkg;

	// Width of the height and climate fields on the ports.
	localparam int FIELD_W = 16;

	// Operation codes carried by the op field.
	localparam logic [1:0] OP_QUERY  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// Insert status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic issue;
		logic load_out;
	} nces_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_query;
		logic count_zero;
		logic scan_last;
		logic pipe_busy;
	} nces_stat_t;

endpackage

>>> design/nces_ctrl.sv
// Controller state machine that sequences accept, table scan, drain and result load.
module nces_ctrl import nces_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  nces_stat_t stat,
	output nces_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	// New words are taken only between operations.
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	// Next state and command decode.
	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.issue    = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (stat.in_query && !stat.count_zero) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (stat.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> design/nces_dp.sv
// Datapath: entry memory, entry count, distance pipeline, best tracker and result register.
module nces_dp import nces_pkg::*; #(
	parameter int MAX_ENTRIES  = 16,
	parameter int CLIMATE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  nces_cmd_t                 cmd,
	output nces_stat_t                stat,
	input  logic [1:0]                op,
	input  logic signed [FIELD_W-1:0] height,
	input  logic signed [FIELD_W-1:0] low_height,
	input  logic signed [FIELD_W-1:0] high_height,
	input  logic [FIELD_W-1:0]        humidity,
	input  logic [FIELD_W-1:0]        temperature,
	input  logic                      underground,
	output logic [3:0]                entry_index,
	output logic                      used_default,
	output logic [1:0]                insert_status
);

	localparam int CB   = (CLIMATE_BITS < FIELD_W) ? CLIMATE_BITS : FIELD_W;
	localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNTW = $clog2(MAX_ENTRIES + 1);
	localparam int DW   = 2 * CB + 1;

	// Entry memory.
	logic signed [FIELD_W-1:0] mem_low   [MAX_ENTRIES];
	logic signed [FIELD_W-1:0] mem_high  [MAX_ENTRIES];
	logic [CB-1:0]             mem_hum   [MAX_ENTRIES];
	logic [CB-1:0]             mem_tmp   [MAX_ENTRIES];
	logic                      mem_under [MAX_ENTRIES];

	logic [CNTW-1:0] count_q;
	logic [IW-1:0]   scan_addr_q;
	logic [IW-1:0]   wr_addr;
	logic            bad_range;
	logic            full;
	logic            do_write;

	// Latched operation and query operands.
	logic [1:0]                op_q;
	logic [1:0]                status_q;
	logic signed [FIELD_W-1:0] q_height_q;
	logic [CB-1:0]             q_hum_q;
	logic [CB-1:0]             q_tmp_q;
	logic                      q_under_q;

	// Scan pipeline.
	logic                      v_s1, v_s2, v_s3;
	logic [IW-1:0]             idx_s1, idx_s2, idx_s3;
	logic signed [FIELD_W-1:0] rd_low_s1, rd_high_s1;
	logic [CB-1:0]             rd_hum_s1, rd_tmp_s1;
	logic                      rd_under_s1;
	logic                      match_s2, match_s3;
	logic [CB-1:0]             dt_s2, dh_s2;
	logic [2*CB-1:0]           sqt_s3, sqh_s3;
	logic [DW-1:0]             sum_sq;
	logic                      upd;

	// Best entry so far.
	logic          found_q;
	logic [DW-1:0] best_q;
	logic [IW-1:0] best_idx_q;
	logic [IW+3:0] best_idx_ext;

	// Result register.
	logic [3:0] entry_index_q;
	logic       used_default_q;
	logic [1:0] insert_status_q;

	// Insert checks against the current table.
	assign bad_range = low_height > high_height;
	assign full      = (count_q == CNTW'(MAX_ENTRIES));
	assign wr_addr   = count_q[IW-1:0];
	assign do_write  = cmd.accept && (op == OP_INSERT) && !bad_range && !full;

	// Status toward the controller.
	assign stat.in_query   = (op == OP_QUERY);
	assign stat.count_zero = (count_q == '0);
	assign stat.scan_last  = ((CNTW'(scan_addr_q) + CNTW'(1)) == count_q);
	assign stat.pipe_busy  = v_s1 || v_s2 || v_s3;

	// Memory write on insert and registered read during the scan.
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem_low[wr_addr]   <= low_height;
			mem_high[wr_addr]  <= high_height;
			mem_hum[wr_addr]   <= humidity[CB-1:0];
			mem_tmp[wr_addr]   <= temperature[CB-1:0];
			mem_under[wr_addr] <= underground;
		end
		if (cmd.issue) begin
			rd_low_s1   <= mem_low[scan_addr_q];
			rd_high_s1  <= mem_high[scan_addr_q];
			rd_hum_s1   <= mem_hum[scan_addr_q];
			rd_tmp_s1   <= mem_tmp[scan_addr_q];
			rd_under_s1 <= mem_under[scan_addr_q];
			idx_s1      <= scan_addr_q;
		end
	end

	// Control registers: count, scan address, stage valids, match flags, found flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			scan_addr_q <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			match_s2    <= 1'b0;
			match_s3    <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (do_write) begin
				count_q <= count_q + CNTW'(1);
			end else if (cmd.accept && (op == OP_CLEAR)) begin
				count_q <= '0;
			end
			if (cmd.accept) begin
				scan_addr_q <= '0;
			end else if (cmd.issue) begin
				scan_addr_q <= scan_addr_q + IW'(1);
			end
			v_s1     <= cmd.issue;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			match_s2 <= v_s1 && (q_height_q <= rd_high_s1) && (q_height_q >= rd_low_s1)
				&& (rd_under_s1 == q_under_q);
			match_s3 <= match_s2;
			if (cmd.accept) begin
				found_q <= 1'b0;
			end else if (upd) begin
				found_q <= 1'b1;
			end
		end
	end

	// Latch the word's operands and the insert status on accept.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q       <= op;
			q_height_q <= height;
			q_hum_q    <= humidity[CB-1:0];
			q_tmp_q    <= temperature[CB-1:0];
			q_under_q  <= underground;
			if (op != OP_INSERT) begin
				status_q <= ST_OK;
			end else if (bad_range) begin
				status_q <= ST_BAD_RANGE;
			end else if (full) begin
				status_q <= ST_FULL;
			end else begin
				status_q <= ST_OK;
			end
		end
	end

	// Absolute differences, then squares.
	always_ff @(posedge clk) begin
		dt_s2  <= (q_tmp_q >= rd_tmp_s1) ? (q_tmp_q - rd_tmp_s1) : (rd_tmp_s1 - q_tmp_q);
		dh_s2  <= (q_hum_q >= rd_hum_s1) ? (q_hum_q - rd_hum_s1) : (rd_hum_s1 - q_hum_q);
		idx_s2 <= idx_s1;
		sqt_s3 <= dt_s2 * dt_s2;
		sqh_s3 <= dh_s2 * dh_s2;
		idx_s3 <= idx_s2;
	end

	// Sum and compare against the best; strict less keeps the first of equal entries.
	assign sum_sq = DW'(sqt_s3) + DW'(sqh_s3);
	assign upd    = match_s3 && (!found_q || (sum_sq < best_q));

	always_ff @(posedge clk) begin
		if (upd) begin
			best_q     <= sum_sq;
			best_idx_q <= idx_s3;
		end
	end

	// Result register, loaded once per operation.
	assign best_idx_ext = (IW + 4)'(best_idx_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (op_q == OP_QUERY) begin
				entry_index_q   <= found_q ? best_idx_ext[3:0] : 4'd0;
				used_default_q  <= !found_q;
				insert_status_q <= ST_OK;
			end else begin
				entry_index_q   <= 4'd0;
				used_default_q  <= 1'b0;
				insert_status_q <= status_q;
			end
		end
	end

	assign entry_index   = entry_index_q;
	assign used_default  = used_default_q;
	assign insert_status = insert_status_q;

endmodule

>>> design/nearest_climate_entry_select.sv
// Top level of the nearest climate entry selector: controller, datapath and checks.
//
// The input channel takes one word per operation: op selects query, insert or clear, and
// the remaining fields carry the query or the entry. Both channels use valid and stall;
// a word moves at a rising edge with valid high and stall low. Every input word yields
// exactly one output word (entry_index, used_default, insert_status), in order.
// Insert, clear, the unused op code and a query on an empty table go from accept straight
// to the done state and load their result once the output register is free; the next
// word is taken only after that. A query reads the entry memory one entry per cycle
// through its single read port and feeds a three-stage distance pipeline; after its
// last entry the pipeline drains, and the result is loaded once the output register is
// free. One operation is in progress at a time; in_stall is high from accept until the
// result is loaded into the output register. The next word is taken while that result
// still waits, and a stalled result holds until the receiver takes it. Reset empties
// the table (entry count zero) and clears the output valid and the pipeline stage valids;
// the entry memory itself is not cleared and needs no clearing pass.
`include "nearest_climate_entry_select_macros.svh"
module nearest_climate_entry_select import nces_pkg::*; #(
	parameter int MAX_ENTRIES  = 16,
	parameter int CLIMATE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                op,
	input  logic signed [FIELD_W-1:0] height,
	input  logic signed [FIELD_W-1:0] low_height,
	input  logic signed [FIELD_W-1:0] high_height,
	input  logic [FIELD_W-1:0]        humidity,
	input  logic [FIELD_W-1:0]        temperature,
	input  logic                      underground,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [3:0]                entry_index,
	output logic                      used_default,
	output logic [1:0]                insert_status
);

	nces_cmd_t  cmd;
	nces_stat_t stat;

	// Sequencing.
	nces_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Table, scan pipeline and result register.
	nces_dp #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.CLIMATE_BITS (CLIMATE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.op            (op),
		.height        (height),
		.low_height    (low_height),
		.high_height   (high_height),
		.humidity      (humidity),
		.temperature   (temperature),
		.underground   (underground),
		.entry_index   (entry_index),
		.used_default  (used_default),
		.insert_status (insert_status)
	);

	// After a word is taken the block is busy on it.
	`NCES_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "busy")
	// The scan only runs over a non-empty table.
	`NCES_ASSERT_IMP(a_scan_nonempty, clk, arst_n, cmd.issue, !stat.count_zero, "empty scan")
	// The scan stops right after its last entry.
	`NCES_ASSERT_NXT(a_scan_stops, clk, arst_n, cmd.issue && stat.scan_last, !cmd.issue, "overrun")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the nearest climate entry selector.
`timescale 1ns / 100ps

module tb_top;
	import nces_pkg::*;

	localparam int TBL_DEPTH = 16;
	localparam int RANDOM_WORDS = 1700;
	localparam int PAUSE_AT = 850;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// One input word and one result word, at the port widths.
	typedef struct packed {
		logic [1:0] op;
		logic [15:0] height;
		logic [15:0] low_height;
		logic [15:0] high_height;
		logic [15:0] humidity;
		logic [15:0] temperature;
		logic underground;
	} climate_word_t;

	typedef struct packed {
		logic [3:0] index;
		logic used_default;
		logic [1:0] status;
	} climate_pick_t;

	typedef struct packed {
		climate_word_t w;
		logic typed;
		climate_pick_t r;
	} directed_row_t;

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	localparam climate_pick_t R_OK = '{4'd0, 1'b0, ST_OK};
	localparam climate_pick_t R_DEFAULT = '{4'd0, 1'b1, ST_OK};
	localparam climate_pick_t R_BAD = '{4'd0, 1'b0, ST_BAD_RANGE};
	localparam climate_pick_t R_FULL = '{4'd0, 1'b0, ST_FULL};

	// Directed words: empty table, bad ranges, fill to full, full insert, ties, clear.
	localparam int N_DIRECTED = 27;
	directed_row_t directed_rows [N_DIRECTED] = '{
		'{'{OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1, R_DEFAULT},
		'{'{OP_UNUSED, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'h0001, 16'h0000, 16'h1234, 16'h4321, 1'b0}, 1'b1, R_BAD},
		'{'{OP_INSERT, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1, R_BAD},
		'{'{OP_INSERT, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b0}, 1'b1, R_OK},
		'{'{OP_QUERY,  16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b0, R_OK},
		'{'{OP_QUERY,  16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0}, 1'b0, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'hFF00, 16'h00FF, 16'h5555, 16'hAAAA, 1'b1}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 16'hAAAA, 16'h5555, 1'b0}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 1'b1}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'h1234, 16'h4321, 16'h0001, 16'hFFFE, 1'b0}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'hC000, 16'h3FFF, 16'h7FFF, 16'h7FFF, 1'b0}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'h8000, 16'h8001, 16'h0F0F, 16'hF0F0, 1'b1}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'h7FFE, 16'h7FFF, 16'hF0F0, 16'h0F0F, 1'b0}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'hFFFF, 16'h0001, 16'h00FF, 16'hFF00, 1'b1}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'h0100, 16'h7000, 16'h3333, 16'hCCCC, 1'b0}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'h9000, 16'hF000, 16'hCCCC, 16'h3333, 1'b1}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b1, R_OK},
		'{'{OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 16'h1111, 16'h2222, 1'b0}, 1'b1, R_FULL},
		'{'{OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b0, R_OK},
		'{'{OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, R_OK},
		'{'{OP_CLEAR,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1, R_OK},
		'{'{OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1, R_DEFAULT}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] op = OP_QUERY;
	logic signed [15:0] height = '0;
	logic signed [15:0] low_height = '0;
	logic signed [15:0] high_height = '0;
	logic [15:0] humidity = '0;
	logic [15:0] temperature = '0;
	logic underground = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] entry_index;
	logic used_default;
	logic [1:0] insert_status;

	// Shadow copy of the entry table.
	logic [15:0] tbl_low [TBL_DEPTH];
	logic [15:0] tbl_high [TBL_DEPTH];
	logic [15:0] tbl_hum [TBL_DEPTH];
	logic [15:0] tbl_temp [TBL_DEPTH];
	logic tbl_under [TBL_DEPTH];
	int tbl_count = 0;

	climate_pick_t expected_picks [$];
	int fail_count = 0;
	int words_in = 0;
	int words_out = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int n_query = 0, n_default = 0, n_insert = 0, n_bad = 0, n_full = 0, n_clear = 0;

	// Receiver state.
	rx_mode_t rx_mode = RX_FREE;
	int rx_mode_left = 0;
	int rx_phase = 0;
	int hold_left = 0;
	int hold_mark = 300;

	nearest_climate_entry_select #(
		.MAX_ENTRIES(TBL_DEPTH),
		.CLIMATE_BITS(16)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.height(height),
		.low_height(low_height),
		.high_height(high_height),
		.humidity(humidity),
		.temperature(temperature),
		.underground(underground),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.entry_index(entry_index),
		.used_default(used_default),
		.insert_status(insert_status)
	);

	always #1 clk = ~clk;

	// Applies one word to the shadow table and returns the pick it must produce.
	function automatic climate_pick_t predict_pick(climate_word_t w);
		climate_pick_t r;
		longint unsigned best;
		longint unsigned sq_dist;
		int dh;
		int dt;
		int i;
		bit found;
		r = R_OK;
		best = 0;
		found = 1'b0;
		case (w.op)
			OP_QUERY: begin
				for (i = 0; i < tbl_count; i++) begin
					if ($signed(w.height) >= $signed(tbl_low[i]) &&
							$signed(w.height) <= $signed(tbl_high[i]) &&
							tbl_under[i] == w.underground) begin
						dh = int'(w.humidity) - int'(tbl_hum[i]);
						dt = int'(w.temperature) - int'(tbl_temp[i]);
						sq_dist = longint'(dh) * longint'(dh) + longint'(dt) * longint'(dt);
						// Strict compare keeps the lowest index on a tie.
						if (!found || sq_dist < best) begin
							found = 1'b1;
							best = sq_dist;
							r.index = 4'(i);
						end
					end
				end
				if (!found) begin
					r.used_default = 1'b1;
					r.index = 4'd0;
				end
			end
			OP_INSERT: begin
				if ($signed(w.low_height) > $signed(w.high_height)) begin
					r.status = ST_BAD_RANGE;
				end else if (tbl_count >= TBL_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					tbl_low[tbl_count] = w.low_height;
					tbl_high[tbl_count] = w.high_height;
					tbl_hum[tbl_count] = w.humidity;
					tbl_temp[tbl_count] = w.temperature;
					tbl_under[tbl_count] = w.underground;
					tbl_count++;
				end
			end
			OP_CLEAR: begin
				tbl_count = 0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Well-formed insert: valid range, often narrow, sometimes sharing a stored climate.
	function automatic climate_word_t make_entry();
		climate_word_t w;
		int lo_i;
		int hi_i;
		int k;
		w.op = OP_INSERT;
		w.height = 16'($urandom);
		w.underground = 1'($urandom);
		lo_i = int'($signed(16'($urandom)));
		case ($urandom_range(0, 9))
			0: begin
				lo_i = -32768;
				hi_i = 32767;
			end
			1: hi_i = lo_i;
			2, 3: hi_i = lo_i + int'($urandom_range(0, 40000));
			default: hi_i = lo_i + int'($urandom_range(0, 3000));
		endcase
		if (hi_i > 32767) begin
			hi_i = 32767;
		end
		w.low_height = lo_i[15:0];
		w.high_height = hi_i[15:0];
		if (tbl_count != 0 && $urandom_range(0, 3) == 0) begin
			k = $urandom_range(0, tbl_count - 1);
			w.humidity = tbl_hum[k];
			w.temperature = tbl_temp[k];
		end else begin
			w.humidity = 16'($urandom);
			w.temperature = 16'($urandom);
		end
		return w;
	endfunction

	// Query, usually aimed at a stored entry: height on, at or just past its range, climate often near it.
	function automatic climate_word_t make_query();
		climate_word_t w;
		int k;
		int lo_i;
		int hi_i;
		int h_i;
		w.op = OP_QUERY;
		w.height = 16'($urandom);
		w.low_height = 16'($urandom);
		w.high_height = 16'($urandom);
		w.humidity = 16'($urandom);
		w.temperature = 16'($urandom);
		w.underground = 1'($urandom);
		if (tbl_count != 0 && $urandom_range(0, 4) != 0) begin
			k = $urandom_range(0, tbl_count - 1);
			lo_i = int'($signed(tbl_low[k]));
			hi_i = int'($signed(tbl_high[k]));
			case ($urandom_range(0, 5))
				0: h_i = lo_i;
				1: h_i = hi_i;
				2: h_i = lo_i - 1;
				3: h_i = hi_i + 1;
				default: h_i = lo_i + int'($urandom_range(0, hi_i - lo_i));
			endcase
			w.height = h_i[15:0];
			w.underground = ($urandom_range(0, 9) == 0) ? ~tbl_under[k] : tbl_under[k];
			case ($urandom_range(0, 3))
				0: begin
					w.humidity = tbl_hum[k];
					w.temperature = tbl_temp[k];
				end
				1, 2: begin
					w.humidity = tbl_hum[k] + 16'($urandom_range(0, 63)) - 16'd32;
					w.temperature = tbl_temp[k] + 16'($urandom_range(0, 63)) - 16'd32;
				end
				default: begin
				end
			endcase
		end
		return w;
	endfunction

	// Offers one word, waits for it to be taken, records its pick, then maybe idles.
	task automatic offer_word(climate_word_t w, logic typed, climate_pick_t typed_pick);
		climate_pick_t r;
		int gap;
		op <= w.op;
		height <= w.height;
		low_height <= w.low_height;
		high_height <= w.high_height;
		humidity <= w.humidity;
		temperature <= w.temperature;
		underground <= w.underground;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		r = predict_pick(w);
		if (typed) begin
			r = typed_pick;
		end
		expected_picks = {expected_picks, r};
		words_in++;
		case (w.op)
			OP_QUERY: begin
				n_query++;
				if (r.used_default) begin
					n_default++;
				end
			end
			OP_INSERT: begin
				n_insert++;
				if (r.status == ST_BAD_RANGE) begin
					n_bad++;
				end
				if (r.status == ST_FULL) begin
					n_full++;
				end
			end
			OP_CLEAR: n_clear++;
			default: begin
			end
		endcase
		// Bursts of back-to-back words separated by random gaps.
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) begin
				@(posedge clk);
			end
		end
	endtask

	// Receiver: changing stall patterns, plus a long hold-off at set word counts.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (words_out == hold_mark) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_mark <= hold_mark + 800;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_mode_left <= $urandom_range(64, 256);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				RX_FREE: out_stall <= 1'b0;
				RX_COIN: out_stall <= 1'($urandom);
				RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (rx_phase % 7) < 3;
			endcase
			rx_phase <= rx_phase + 1;
		end
	end

	// Result checker: each word taken is compared with the oldest pending pick.
	always @(posedge clk) begin
		climate_pick_t want;
		if (arst_n && out_valid && !out_stall) begin
			words_out <= words_out + 1;
			if (expected_picks.size() == 0) begin
				$error("result word arrived with no pick pending");
				fail_count++;
			end else begin
				want = expected_picks.pop_front();
				if (entry_index !== want.index) begin
					$error("entry_index: expected %0d, got %0d", want.index, entry_index);
					fail_count++;
				end
				if (used_default !== want.used_default) begin
					$error("used_default: expected %0d, got %0d", want.used_default,
						used_default);
					fail_count++;
				end
				if (insert_status !== want.status) begin
					$error("insert_status: expected %0d, got %0d", want.status, insert_status);
					fail_count++;
				end
			end
		end
	end

	// Cycles in which neither channel moved a word.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog.
	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// Stimulus: reset, directed table, then random sequences.
	initial begin
		int row;
		bit paused;
		paused = 1'b0;
		repeat (6) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < N_DIRECTED; row++) begin
			offer_word(directed_rows[row].w, directed_rows[row].typed, directed_rows[row].r);
		end

		while (words_in < N_DIRECTED + RANDOM_WORDS) begin
			// Once, let everything drain with the sender quiet.
			if (!paused && words_in >= N_DIRECTED + PAUSE_AT) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				while (expected_picks.size() != 0) begin
					@(posedge clk);
				end
				@(posedge clk);
			end
			if ($urandom_range(0, 9) < 7) begin
				// Well-formed sequence: optional clear, some inserts, then aimed queries.
				if ($urandom_range(0, 2) == 0) begin
					offer_word('{OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom), 1'($urandom)}, 1'b0, R_OK);
				end
				repeat (($urandom_range(0, 5) == 0) ? 18 : $urandom_range(1, 8)) begin
					offer_word(make_entry(), 1'b0, R_OK);
				end
				repeat ($urandom_range(2, 12)) begin
					offer_word(make_query(), 1'b0, R_OK);
				end
			end else begin
				// Noise: any op code, any field values.
				repeat ($urandom_range(1, 6)) begin
					offer_word('{2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom), 1'($urandom)}, 1'b0, R_OK);
				end
			end
		end

		in_valid <= 1'b0;
		while (expected_picks.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) begin
			@(posedge clk);
		end

		$display("Sent %0d words: %0d queries (%0d took the default), %0d clears.",
			words_in, n_query, n_default, n_clear);
		$display("Inserts: %0d, of which %0d had a bad range and %0d found the table full.",
			n_insert, n_bad, n_full);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> nearest_climate_entry_select.f
+incdir+design
design/nces_pkg.sv
design/nces_ctrl.sv
design/nces_dp.sv
design/nearest_climate_entry_select.sv
tb/tb_top.sv
